### hw/rtl/fdr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fdr_pkg: shared constants for the dielectric Fresnel reflectance block
// Field widths, register reset values and register index codes.
// ----------------------------------------------------------------------------
package fdr_pkg;

    localparam int FRAC_BITS_DEF = 15;   // internal fraction bits
    localparam int ETA_W         = 16;   // Q4.12 index registers
    localparam int IO_W          = 16;   // cosine in, reflectance out
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;

    localparam logic [ETA_W-1:0] ETA_RESET = 16'd4096;
    localparam logic [IO_W-1:0]  REFL_ONE  = 16'h8000;

    // register index, taken from paddr[2]
    localparam logic REG_ETA_INCIDENT = 1'b0;
    localparam logic REG_ETA_TRANSMIT = 1'b1;

endpackage
`default_nettype wire

### hw/rtl/fresnel_dielectric_reflectance.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fresnel_dielectric_reflectance: unpolarized dielectric Fresnel reflectance
// Two square roots of FRAC_BITS+1 stages and two dividers of FRAC_BITS stages
// in series, one bit each; the two ratio dividers run side by side.
// Throughput one item per cycle; a stalled output holds the whole pipeline.
// Reset clears all valid bits and sets both indices to 1.0; no clearing pass.
// ----------------------------------------------------------------------------
module fresnel_dielectric_reflectance #(
    parameter int FRAC_BITS = fdr_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [fdr_pkg::APB_AW-1:0]  paddr,
    input  wire logic [fdr_pkg::APB_DW-1:0]  pwdata,
    output logic      [fdr_pkg::APB_DW-1:0]  prdata,
    output logic                             pready,
    input  wire logic                        cos_valid,
    output logic                             cos_stall,
    input  wire logic signed [fdr_pkg::IO_W-1:0] cos_incident,
    output logic                             refl_valid,
    input  wire logic                        refl_stall,
    output logic      [fdr_pkg::IO_W-1:0]    reflectance
);

    import fdr_pkg::*;

    localparam int F   = FRAC_BITS;
    localparam int CW  = F + 1;             // cosine / sine width, up to 1.0
    localparam int NW  = ETA_W + CW;        // index * cosine product
    localparam int D1W = ETA_W + F;         // Snell division width
    localparam int D2W = NW + 1;            // ratio division width
    localparam int SW1 = CW + 2 * ETA_W;
    localparam int SW2 = SW1 + 1;

    localparam logic [2*CW-1:0] ONE_SQ = (2 * CW)'(1) << (2 * F);
    localparam logic [CW-1:0]   ONE_C  = CW'(1) << F;

    // ---------------- configuration ----------------
    logic [ETA_W-1:0] eta_i_reg;
    logic [ETA_W-1:0] eta_t_reg;
    logic             cfg_wr;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ETA_TRANSMIT) ? APB_DW'(eta_t_reg) : APB_DW'(eta_i_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eta_i_reg <= ETA_RESET;
            eta_t_reg <= ETA_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_ETA_INCIDENT)
            begin
                eta_i_reg <= pwdata[ETA_W-1:0];
            end
            else
            begin
                eta_t_reg <= pwdata[ETA_W-1:0];
            end
        end
    end

    // ---------------- flow control ----------------
    logic advance;
    logic out_vld_reg;

    assign advance   = !(out_vld_reg && refl_stall);
    assign cos_stall = !advance;

    // ---------------- stage 0: magnitude, swap ----------------
    logic [16:0]     mag;
    logic            entering;
    logic [F+16:0]   cos_scaled;
    logic            s0_vld_reg;
    logic [CW-1:0]   s0_cos_reg;
    logic [ETA_W-1:0] s0_ei_reg, s0_et_reg;

    assign entering   = (cos_incident != '0) && !cos_incident[IO_W-1];
    assign mag        = cos_incident[IO_W-1] ? (17'h10000 - {1'b0, cos_incident})
                                             : {1'b0, cos_incident};
    assign cos_scaled = {mag, {F{1'b0}}} >> 15;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_cos_reg <= cos_scaled[CW-1:0];
            s0_ei_reg  <= entering ? eta_i_reg : eta_t_reg;
            s0_et_reg  <= entering ? eta_t_reg : eta_i_reg;
        end
    end

    // ---------------- stage 1: 1 - cos^2 ----------------
    logic            s1_vld_reg;
    logic [2*CW-1:0] s1_rad_reg;
    logic [SW1-1:0]  s1_side_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_rad_reg  <= ONE_SQ - ((2 * CW)'(s0_cos_reg) * (2 * CW)'(s0_cos_reg));
            s1_side_reg <= {s0_cos_reg, s0_ei_reg, s0_et_reg};
        end
    end

    logic           q1_vld;
    logic [CW-1:0]  sin_i;
    logic [SW1-1:0] q1_side;

    fdr_isqrt #(.RW(CW), .SW(SW1)) u_sqrt_sin (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_vld   (s1_vld_reg),
        .in_rad   (s1_rad_reg),
        .in_side  (s1_side_reg),
        .out_vld  (q1_vld),
        .out_root (sin_i),
        .out_side (q1_side)
    );

    // ---------------- stage 2: eta_i * sin_i ----------------
    logic            s2_vld_reg;
    logic [NW-1:0]   s2_n_reg;
    logic [SW1-1:0]  s2_side_reg;
    logic [ETA_W-1:0] q1_ei;

    assign q1_ei = q1_side[2*ETA_W-1:ETA_W];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_n_reg    <= NW'(q1_ei) * NW'(sin_i);
            s2_side_reg <= q1_side;
        end
    end

    // ---------------- stage 3: total internal reflection check ----------------
    logic             s3_vld_reg;
    logic [D1W-1:0]   s3_num_reg, s3_den_reg;
    logic [SW2-1:0]   s3_side_reg;
    logic [ETA_W-1:0] s2_et;
    logic [D1W-1:0]   snell_den;
    logic             tir;

    assign s2_et     = s2_side_reg[ETA_W-1:0];
    assign snell_den = {s2_et, {F{1'b0}}};
    assign tir       = (s2_et == '0) || (s2_n_reg >= NW'(snell_den));

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_num_reg  <= tir ? '0 : s2_n_reg[D1W-1:0];
            s3_den_reg  <= tir ? D1W'(1) : snell_den;
            s3_side_reg <= {s2_side_reg, tir};
        end
    end

    logic           q2_vld;
    logic [F-1:0]   sin_t;
    logic [SW2-1:0] q2_side;

    fdr_div #(.DW(D1W), .QW(F), .SW(SW2)) u_div_snell (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_vld   (s3_vld_reg),
        .in_num   (s3_num_reg),
        .in_den   (s3_den_reg),
        .in_side  (s3_side_reg),
        .out_vld  (q2_vld),
        .out_quo  (sin_t),
        .out_side (q2_side)
    );

    // ---------------- stage 4: 1 - sin_t^2 ----------------
    logic            s4_vld_reg;
    logic [2*CW-1:0] s4_rad_reg;
    logic [SW2-1:0]  s4_side_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s4_rad_reg  <= ONE_SQ - ((2 * CW)'(sin_t) * (2 * CW)'(sin_t));
            s4_side_reg <= q2_side;
        end
    end

    logic           q3_vld;
    logic [CW-1:0]  cos_t;
    logic [SW2-1:0] q3_side;

    fdr_isqrt #(.RW(CW), .SW(SW2)) u_sqrt_cos (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_vld   (s4_vld_reg),
        .in_rad   (s4_rad_reg),
        .in_side  (s4_side_reg),
        .out_vld  (q3_vld),
        .out_root (cos_t),
        .out_side (q3_side)
    );

    // ---------------- stage 5: index-cosine products ----------------
    logic             s5_vld_reg;
    logic [NW-1:0]    s5_a1_reg, s5_b1_reg, s5_a2_reg, s5_b2_reg;
    logic             s5_tir_reg;
    logic [CW-1:0]    q3_cos_i;
    logic [ETA_W-1:0] q3_ei, q3_et;

    assign q3_cos_i = q3_side[SW2-1 -: CW];
    assign q3_ei    = q3_side[2*ETA_W:ETA_W+1];
    assign q3_et    = q3_side[ETA_W:1];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s5_a1_reg  <= NW'(q3_et) * NW'(q3_cos_i);
            s5_b1_reg  <= NW'(q3_ei) * NW'(cos_t);
            s5_a2_reg  <= NW'(q3_ei) * NW'(q3_cos_i);
            s5_b2_reg  <= NW'(q3_et) * NW'(cos_t);
            s5_tir_reg <= q3_side[0];
        end
    end

    // ---------------- stage 6: ratio numerators and denominators ----------------
    // a zero product makes the ratio exactly one (also covers a zero denominator)
    logic           s6_vld_reg;
    logic [D2W-1:0] s6_num1_reg, s6_den1_reg, s6_num2_reg, s6_den2_reg;
    logic           s6_full1_reg, s6_full2_reg, s6_tir_reg;
    logic           full1, full2;

    assign full1 = (s5_a1_reg == '0) || (s5_b1_reg == '0);
    assign full2 = (s5_a2_reg == '0) || (s5_b2_reg == '0);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s6_num1_reg  <= full1 ? '0 : ((s5_a1_reg >= s5_b1_reg) ?
                            D2W'(s5_a1_reg - s5_b1_reg) : D2W'(s5_b1_reg - s5_a1_reg));
            s6_den1_reg  <= full1 ? D2W'(1) : (D2W'(s5_a1_reg) + D2W'(s5_b1_reg));
            s6_num2_reg  <= full2 ? '0 : ((s5_a2_reg >= s5_b2_reg) ?
                            D2W'(s5_a2_reg - s5_b2_reg) : D2W'(s5_b2_reg - s5_a2_reg));
            s6_den2_reg  <= full2 ? D2W'(1) : (D2W'(s5_a2_reg) + D2W'(s5_b2_reg));
            s6_full1_reg <= full1;
            s6_full2_reg <= full2;
            s6_tir_reg   <= s5_tir_reg;
        end
    end

    logic         q4_vld;
    logic         q5_vld_unused;
    logic [F-1:0] r1_q, r2_q;
    logic [1:0]   q4_side;
    logic         q5_side;

    fdr_div #(.DW(D2W), .QW(F), .SW(2)) u_div_par (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_vld   (s6_vld_reg),
        .in_num   (s6_num1_reg),
        .in_den   (s6_den1_reg),
        .in_side  ({s6_tir_reg, s6_full1_reg}),
        .out_vld  (q4_vld),
        .out_quo  (r1_q),
        .out_side (q4_side)
    );

    fdr_div #(.DW(D2W), .QW(F), .SW(1)) u_div_perp (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_vld   (s6_vld_reg),
        .in_num   (s6_num2_reg),
        .in_den   (s6_den2_reg),
        .in_side  (s6_full2_reg),
        .out_vld  (q5_vld_unused),
        .out_quo  (r2_q),
        .out_side (q5_side)
    );

    // ---------------- stage 7: squared ratios ----------------
    logic            s7_vld_reg;
    logic [CW-1:0]   s7_sq1_reg, s7_sq2_reg;
    logic            s7_tir_reg;
    logic [CW-1:0]   r1, r2;
    logic [2*CW-1:0] r1_sq, r2_sq;

    assign r1    = q4_side[0] ? ONE_C : {1'b0, r1_q};
    assign r2    = q5_side ? ONE_C : {1'b0, r2_q};
    assign r1_sq = ((2 * CW)'(r1) * (2 * CW)'(r1)) >> F;
    assign r2_sq = ((2 * CW)'(r2) * (2 * CW)'(r2)) >> F;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s7_sq1_reg <= r1_sq[CW-1:0];
            s7_sq2_reg <= r2_sq[CW-1:0];
            s7_tir_reg <= q4_side[1];
        end
    end

    // ---------------- stage 8: mean, Q1.15 output register ----------------
    logic [CW:0]      sq_sum;
    logic [CW-1:0]    mean;
    logic [CW+14:0]   res_wide;
    logic [IO_W-1:0]  refl_reg;

    assign sq_sum   = {1'b0, s7_sq1_reg} + {1'b0, s7_sq2_reg};
    assign mean     = sq_sum[CW:1];
    assign res_wide = {mean, 15'd0} >> F;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (s7_tir_reg || (res_wide >= (CW + 15)'(REFL_ONE)))
            begin
                refl_reg <= REFL_ONE;
            end
            else
            begin
                refl_reg <= res_wide[IO_W-1:0];
            end
        end
    end

    // ---------------- valid bits ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg  <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            s6_vld_reg  <= 1'b0;
            s7_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            s0_vld_reg  <= cos_valid;
            s1_vld_reg  <= s0_vld_reg;
            s2_vld_reg  <= q1_vld;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= q2_vld;
            s5_vld_reg  <= q3_vld;
            s6_vld_reg  <= s5_vld_reg;
            s7_vld_reg  <= q4_vld && q5_vld_unused;
            out_vld_reg <= s7_vld_reg;
        end
    end

    assign refl_valid  = out_vld_reg;
    assign reflectance = refl_reg;

endmodule
`default_nettype wire

### hw/rtl/fdr_isqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fdr_isqrt: pipelined integer square root
// floor(sqrt(rad)), one result bit per register stage, side data carried along.
// ----------------------------------------------------------------------------
module fdr_isqrt #(
    parameter int RW = 16,    // root width; radicand is 2*RW bits
    parameter int SW = 1      // side data width
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            advance,
    input  wire logic            in_vld,
    input  wire logic [2*RW-1:0] in_rad,
    input  wire logic [SW-1:0]   in_side,
    output logic                 out_vld,
    output logic [RW-1:0]        out_root,
    output logic [SW-1:0]        out_side
);

    logic            vld_reg  [RW];
    logic [2*RW-1:0] rad_reg  [RW];
    logic [RW+1:0]   rem_reg  [RW];
    logic [RW-1:0]   res_reg  [RW];
    logic [SW-1:0]   side_reg [RW];

    for (genvar k = 0; k < RW; k++) begin : g_step
        logic            p_vld;
        logic [2*RW-1:0] p_rad;
        logic [RW+1:0]   p_rem;
        logic [RW-1:0]   p_res;
        logic [SW-1:0]   p_side;
        logic [RW+3:0]   sh;
        logic [RW+3:0]   trial;
        logic [RW+3:0]   diff;
        logic            ge;
        logic [RW+1:0]   rem_next;
        logic [RW-1:0]   res_next;

        if (k == 0) begin : g_first
            assign p_vld  = in_vld;
            assign p_rad  = in_rad;
            assign p_rem  = '0;
            assign p_res  = '0;
            assign p_side = in_side;
        end
        else begin : g_rest
            assign p_vld  = vld_reg[k-1];
            assign p_rad  = rad_reg[k-1];
            assign p_rem  = rem_reg[k-1];
            assign p_res  = res_reg[k-1];
            assign p_side = side_reg[k-1];
        end

        // bring down the next two radicand bits, try (4*root + 1)
        assign sh       = {p_rem, p_rad[2*RW-1 -: 2]};
        assign trial    = {2'b00, p_res, 2'b01};
        assign ge       = (sh >= trial);
        assign diff     = sh - trial;
        assign rem_next = ge ? diff[RW+1:0] : sh[RW+1:0];
        assign res_next = {p_res[RW-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (advance)
            begin
                vld_reg[k] <= p_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rad_reg[k]  <= {p_rad[2*RW-3:0], 2'b00};
                rem_reg[k]  <= rem_next;
                res_reg[k]  <= res_next;
                side_reg[k] <= p_side;
            end
        end
    end

    assign out_vld  = vld_reg[RW-1];
    assign out_root = res_reg[RW-1];
    assign out_side = side_reg[RW-1];

endmodule
`default_nettype wire

### hw/rtl/fdr_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fdr_div: pipelined fractional divider
// floor(num * 2^QW / den) for num < den, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module fdr_div #(
    parameter int DW = 32,    // numerator / denominator width
    parameter int QW = 16,    // quotient width
    parameter int SW = 1      // side data width
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          advance,
    input  wire logic          in_vld,
    input  wire logic [DW-1:0] in_num,
    input  wire logic [DW-1:0] in_den,
    input  wire logic [SW-1:0] in_side,
    output logic               out_vld,
    output logic [QW-1:0]      out_quo,
    output logic [SW-1:0]      out_side
);

    logic          vld_reg  [QW];
    logic [DW-1:0] rem_reg  [QW];
    logic [DW-1:0] den_reg  [QW];
    logic [QW-1:0] quo_reg  [QW];
    logic [SW-1:0] side_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic          p_vld;
        logic [DW-1:0] p_rem;
        logic [DW-1:0] p_den;
        logic [QW-1:0] p_quo;
        logic [SW-1:0] p_side;
        logic [DW:0]   sh;
        logic [DW:0]   diff;
        logic          ge;
        logic [DW-1:0] rem_next;

        if (k == 0) begin : g_first
            assign p_vld  = in_vld;
            assign p_rem  = in_num;
            assign p_den  = in_den;
            assign p_quo  = '0;
            assign p_side = in_side;
        end
        else begin : g_rest
            assign p_vld  = vld_reg[k-1];
            assign p_rem  = rem_reg[k-1];
            assign p_den  = den_reg[k-1];
            assign p_quo  = quo_reg[k-1];
            assign p_side = side_reg[k-1];
        end

        assign sh       = {p_rem, 1'b0};
        assign ge       = (sh >= {1'b0, p_den});
        assign diff     = sh - {1'b0, p_den};
        assign rem_next = ge ? diff[DW-1:0] : sh[DW-1:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (advance)
            begin
                vld_reg[k] <= p_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_reg[k]  <= rem_next;
                den_reg[k]  <= p_den;
                quo_reg[k]  <= {p_quo[QW-2:0], ge};
                side_reg[k] <= p_side;
            end
        end
    end

    assign out_vld  = vld_reg[QW-1];
    assign out_quo  = quo_reg[QW-1];
    assign out_side = side_reg[QW-1];

endmodule
`default_nettype wire

### dv/fdr_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fdr_checker: scoreboard for the dielectric Fresnel reflectance block
// Watches the cosine and reflectance channels and the register port, predicts
// each reflectance in fixed point and compares in order.
// ----------------------------------------------------------------------------
module fdr_checker #(
    parameter int FRAC_BITS = fdr_pkg::FRAC_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic                             pready,
    input  wire logic [fdr_pkg::APB_AW-1:0]       paddr,
    input  wire logic [fdr_pkg::APB_DW-1:0]       pwdata,
    input  wire logic                             cos_valid,
    input  wire logic                             cos_stall,
    input  wire logic signed [fdr_pkg::IO_W-1:0]  cos_incident,
    input  wire logic                             refl_valid,
    input  wire logic                             refl_stall,
    input  wire logic [fdr_pkg::IO_W-1:0]         reflectance,
    output int                                    fail_count,
    output int                                    pending,
    output int                                    refl_seen
);
    import fdr_pkg::*;

    localparam longint unsigned ONE = 64'd1 << FRAC_BITS;

    logic [ETA_W-1:0] eta_i_reg;
    logic [ETA_W-1:0] eta_t_reg;
    logic [IO_W-1:0]  refl_expected[$];

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned fresnel_sq(longint unsigned a, longint unsigned b);
        longint unsigned den;
        longint unsigned num;
        longint unsigned q;
        den = a + b;
        num = (a >= b) ? a - b : b - a;
        if (den == 0) return ONE;
        if (num >= den) q = ONE;
        else
        begin
            q = 0;
            for (int i = 0; i < FRAC_BITS; i++)
            begin
                num <<= 1;
                q <<= 1;
                if (num >= den)
                begin
                    num -= den;
                    q |= 1;
                end
            end
        end
        return (q * q) >> FRAC_BITS;
    endfunction

    function automatic logic [IO_W-1:0] predict_reflectance(logic [IO_W-1:0] c);
        longint unsigned mag, ei, et, ci, si, st, ct, mean, res;
        bit entering;
        int up;
        int dn;
        up = (FRAC_BITS >= 15) ? FRAC_BITS - 15 : 0;
        dn = (FRAC_BITS < 15) ? 15 - FRAC_BITS : 0;
        entering = (c != 0) && !c[15];
        mag = c[15] ? 64'h10000 - c : c;
        ei = entering ? eta_i_reg : eta_t_reg;
        et = entering ? eta_t_reg : eta_i_reg;
        ci = (mag << up) >> dn;
        if (ci > ONE) ci = ONE;
        si = int_sqrt(ONE * ONE - ci * ci);
        if (et == 0) return REFL_ONE;
        st = (ei * si) / et;
        if (st >= ONE) return REFL_ONE;
        ct = int_sqrt(ONE * ONE - st * st);
        mean = (fresnel_sq(et * ci, ei * ct) + fresnel_sq(ei * ci, et * ct)) >> 1;
        res = (mean >> up) << dn;
        if (res > 32768) res = 32768;
        return res[IO_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [IO_W-1:0] want;
        if (!rst_n)
        begin
            eta_i_reg  <= ETA_RESET;
            eta_t_reg  <= ETA_RESET;
            fail_count <= 0;
            pending    <= 0;
            refl_seen  <= 0;
            refl_expected.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_ETA_INCIDENT) eta_i_reg <= pwdata[ETA_W-1:0];
                else eta_t_reg <= pwdata[ETA_W-1:0];
            end
            if (cos_valid && !cos_stall)
                refl_expected.push_back(predict_reflectance(cos_incident));
            if (refl_valid && !refl_stall)
            begin
                refl_seen <= refl_seen + 1;
                if (refl_expected.size() == 0)
                begin
                    if (fail_count < 10) $display("unexpected reflectance %0d", reflectance);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = refl_expected.pop_front();
                    if (want !== reflectance)
                    begin
                        if (fail_count < 10)
                            $display("reflectance mismatch: expected %0d got %0d",
                                     want, reflectance);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= refl_expected.size();
        end
    end
endmodule
`default_nettype wire

### dv/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// testbench: top level for the dielectric Fresnel reflectance block
// Drives cosines under several index settings with random stalls and gaps;
// the checker predicts and compares every reflectance.
// ----------------------------------------------------------------------------
module testbench;
    import fdr_pkg::*;

    localparam int LATENCY = 4 * FRAC_BITS_DEF + 11;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic pready;
    logic cos_valid = 1'b0;
    logic cos_stall;
    logic signed [IO_W-1:0] cos_incident = '0;
    logic refl_valid;
    logic refl_stall = 1'b0;
    logic [IO_W-1:0] reflectance;
    int fail_count;
    int pending;
    int refl_seen;
    int cos_sent = 0;
    bit calm = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    fresnel_dielectric_reflectance dut (.*);
    fdr_checker chk (.*);

    initial
    begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

    // random receiver stalls in bursts
    initial
    begin
        int n;
        forever
        begin
            n = $urandom_range(1, 16);
            repeat (n) @(negedge clk);
            refl_stall <= !calm && ($urandom_range(0, 2) == 0);
        end
    end

    task automatic write_eta(logic idx, logic [15:0] val);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= {16'd0, val};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // valid stays high between items unless a gap is drawn
    task automatic send_cos(logic [15:0] c);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            cos_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        cos_valid <= 1'b1;
        cos_incident <= c;
        @(posedge clk);
        while (cos_stall) @(posedge clk);
        cos_sent++;
        @(negedge clk);
    endtask

    task automatic settle;
        cos_valid <= 1'b0;
        while (pending != 0 || cos_valid) @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    function automatic logic [15:0] rand_cos;
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h0000;
            2: return 16'h7fff;
            3: return 16'($urandom_range(0, 40));
            4: return 16'(32'h10000 - $urandom_range(1, 40));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    initial
    begin
        logic [15:0] dir_cos[] = '{16'h0000, 16'h8000, 16'h7fff, 16'h0001,
                                   16'hffff, 16'h4000, 16'hc000, 16'h5555,
                                   16'haaaa, 16'h2000};
        logic [15:0] etas[][2] = '{'{16'd4096, 16'd6144}, '{16'd6144, 16'd4096},
                                   '{16'd1, 16'd65535}, '{16'd65535, 16'd1},
                                   '{16'd65535, 16'd65535}, '{16'd1, 16'd1},
                                   '{16'd5461, 16'd4096}};
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        foreach (dir_cos[k]) send_cos(dir_cos[k]);
        settle();
        foreach (etas[s])
        begin
            write_eta(REG_ETA_INCIDENT, etas[s][0]);
            write_eta(REG_ETA_TRANSMIT, etas[s][1]);
            foreach (dir_cos[k]) if (k < 3) send_cos(dir_cos[k]);
            repeat (200) send_cos(rand_cos());
            settle();
        end
        write_eta(REG_ETA_INCIDENT, 16'($urandom_range(1, 65535)));
        write_eta(REG_ETA_TRANSMIT, 16'($urandom_range(1, 65535)));
        calm = 1'b1;
        repeat (100) send_cos(rand_cos());
        settle();
        $display("sent %0d cosines under %0d index settings, %0d reflectances checked",
                 cos_sent, etas.size() + 2, refl_seen);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire

### filelist.f
hw/rtl/fdr_pkg.sv
hw/rtl/fdr_isqrt.sv
hw/rtl/fdr_div.sv
hw/rtl/fresnel_dielectric_reflectance.sv
dv/fdr_checker.sv
dv/testbench.sv
